// File: rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared constants and types for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int ELEM_W = 16;
    localparam int DIM    = 4;
    localparam int IDX_W  = $clog2(DIM);
    localparam int LOAD_W = $clog2(2 * DIM);
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int FRAC_W = 4;
    localparam int ROW_W  = DIM * ELEM_W;
    localparam int DATA_W = ((ROW_W + 7) / 8) * 8;

    localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(8);

    localparam logic signed [ACC_W-1:0] ACC_EMAX = ACC_W'((64'sd1 <<< (ELEM_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_EMIN = ~ACC_EMAX;

    typedef logic signed [ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_lane_op;

    typedef struct packed {
        logic  valid;
        t_elem value;
        logic  clip;
    } t_lane_res;

endpackage

// File: rtl/matrix4x4_multiply_top.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply_top
// Loads a left and a right 4x4 signed fixed-point matrix one row per transfer
// and streams out the four rows of their product, shifted and saturated.
//
// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata[63:0]        one matrix row
// m_axis    out        tvalid tready tdata tlast tuser  one product row
// cfg       in         i_cfg_valid o_cfg_ready data[3:0]  fraction bits
//
// Rows are loaded at one transfer per cycle. After the eighth row the four
// lanes run four multiply-accumulate steps per product row; each result
// then passes the product, accumulator and result registers of the lanes
// and the output register before it is shown on m_axis.
// Reset is synchronous; the matrix stores themselves are not cleared.
// A stalled sink holds the sequencer before it starts the next row.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_top
    import mm4_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DATA_W-1:0]   s_axis_tdata,  // elem_col0, elem_col1, elem_col2, elem_col3
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DATA_W-1:0]   m_axis_tdata,  // prod_col0, prod_col1, prod_col2, prod_col3
    output logic                m_axis_tlast,
    output logic                m_axis_tuser,  // saturated
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [FRAC_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_ISSUE,
        S_WAIT,
        S_GAP
    } t_state;

    t_state              r_state;
    logic [LOAD_W-1:0]   r_rows;
    logic [IDX_W-1:0]    r_row;
    logic [IDX_W-1:0]    r_k;
    logic [FRAC_W-1:0]   r_frac;
    t_elem               r_left  [DIM][DIM];
    t_elem               r_right [DIM][DIM];

    logic                in_xfer;
    logic                row_done;
    logic                out_busy;
    t_lane_op            op;
    t_lane_res           lane_res [DIM];

    assign s_axis_tready = (r_state == S_LOAD);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign op.valid = (r_state == S_ISSUE);
    assign op.first = (r_k == '0);
    assign op.last  = (r_k == IDX_W'(DIM - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= FRAC_RESET;
        end else if (i_cfg_valid) begin
            r_frac <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int j = 0; j < DIM; j++) begin
                if (!r_rows[LOAD_W-1]) begin
                    r_left[r_rows[IDX_W-1:0]][j] <= t_elem'(s_axis_tdata[j*ELEM_W +: ELEM_W]);
                end else begin
                    r_right[r_rows[IDX_W-1:0]][j] <= t_elem'(s_axis_tdata[j*ELEM_W +: ELEM_W]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rows  <= '0;
            r_row   <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        r_rows <= r_rows + 1'b1;
                        if (r_rows == LOAD_W'(2 * DIM - 1)) begin
                            r_row   <= '0;
                            r_k     <= '0;
                            r_state <= S_GAP;
                        end
                    end
                end
                S_ISSUE: begin
                    r_k <= r_k + 1'b1;
                    if (op.last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (row_done) begin
                        if (r_row == IDX_W'(DIM - 1)) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_state <= S_GAP;
                        end
                    end
                end
                S_GAP: begin
                    if (!out_busy) begin
                        r_state <= S_ISSUE;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    for (genvar c = 0; c < DIM; c++) begin : g_lane
        mm4_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (op),
            .i_a     (r_left[r_row][r_k]),
            .i_b     (r_right[r_k][c]),
            .i_frac  (r_frac),
            .o_res   (lane_res[c])
        );
    end

    mm4_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lane     (lane_res),
        .i_last     (r_row == IDX_W'(DIM - 1)),
        .o_row_done (row_done),
        .o_busy     (out_busy),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tlast    (m_axis_tlast),
        .o_tuser    (m_axis_tuser)
    );

endmodule

// File: rtl/mm4_lane.sv
// ----------------------------------------------------------------------------
// mm4_lane
// One multiply-accumulate lane: forms one product element over DIM steps,
// then shifts it by the fraction bits and saturates it to the element range.
// ----------------------------------------------------------------------------
module mm4_lane
    import mm4_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_op            i_op,
    input  t_elem               i_a,
    input  t_elem               i_b,
    input  logic [FRAC_W-1:0]   i_frac,
    output t_lane_res           o_res
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvalid;
    logic                     r_pfirst;
    logic                     r_plast;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     r_adone;
    logic signed [ACC_W-1:0]  shifted;
    t_lane_res                r_res;
    t_lane_res                n_res;

    always_comb begin
        n_acc = r_pfirst ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        shifted = r_acc >>> i_frac;
        n_res.valid = r_adone;
        if (shifted > ACC_EMAX) begin
            n_res.value = t_elem'(ACC_EMAX[ELEM_W-1:0]);
            n_res.clip  = 1'b1;
        end else if (shifted < ACC_EMIN) begin
            n_res.value = t_elem'(ACC_EMIN[ELEM_W-1:0]);
            n_res.clip  = 1'b1;
        end else begin
            n_res.value = t_elem'(shifted[ELEM_W-1:0]);
            n_res.clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid    <= 1'b0;
            r_adone     <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_pvalid <= i_op.valid;
            r_adone  <= r_pvalid && r_plast;
            r_res    <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= i_a * i_b;
        r_pfirst <= i_op.first;
        r_plast  <= i_op.last;
        if (r_pvalid) begin
            r_acc <= n_acc;
        end
    end

    assign o_res = r_res;

endmodule

// File: rtl/mm4_merge.sv
// ----------------------------------------------------------------------------
// mm4_merge
// Gathers the lane results into one product row, combines the clip flags
// and holds the row in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module mm4_merge
    import mm4_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_res           i_lane [DIM],
    input  logic                i_last,
    output logic                o_row_done,
    output logic                o_busy,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [DATA_W-1:0]   o_tdata,
    output logic                o_tlast,
    output logic                o_tuser
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              r_last;
    logic              r_sat;
    logic [DATA_W-1:0] n_data;
    logic              n_sat;

    always_comb begin
        n_data = '0;
        n_sat  = 1'b0;
        for (int c = 0; c < DIM; c++) begin
            n_data[c*ELEM_W +: ELEM_W] = i_lane[c].value;
            n_sat = n_sat | i_lane[c].clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_lane[0].valid) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lane[0].valid) begin
            r_data <= n_data;
            r_last <= i_last;
            r_sat  <= n_sat;
        end
    end

    assign o_row_done = i_lane[0].valid;
    assign o_busy     = r_valid && !i_tready;
    assign o_tvalid   = r_valid;
    assign o_tdata    = r_data;
    assign o_tlast    = r_last;
    assign o_tuser    = r_sat;

endmodule

// File: rtl/mm4_checker.sv
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks on the matrix multiplier, bound to its top level.
// ----------------------------------------------------------------------------
module mm4_checker
    import mm4_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [DATA_W-1:0]   m_axis_tdata,
    input  logic                m_axis_tlast
);

    // A stalled product row must keep its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("product row changed while stalled");

    // Loading stops only after an input transfer completed the second matrix.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("input ready dropped without a transfer");

    // A product row appears only while loading is closed.
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("product row appeared during loading");

    // Rows before the final one are shown only while the block computes.
    a_mid_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted while product rows remain");

endmodule

bind matrix4x4_multiply_top mm4_checker u_mm4_checker (.*);
